### src/isq_pkg.sv
`timescale 1ns / 1ps

package isq_pkg;

    // Sizing of the store.
    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;

    // Fixed widths of the port fields.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Internal widths derived from the sizing.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_INSERT_AT  = 3'd2,
        K_POP_FRONT  = 3'd3,
        K_POP_BACK   = 3'd4,
        K_REMOVE_AT  = 3'd5,
        K_READ_AT    = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell does on a given cycle.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_OPEN  = 2'd1,
        SH_CLOSE = 2'd2
    } shift_t;

    // Command broadcast along the row of cells.
    typedef struct packed {
        shift_t                op;
        logic [IDX_W-1:0]      at;
        logic [CNT_W-1:0]      count;
        logic [ITEM_WIDTH-1:0] value;
        logic [IDX_W-1:0]      rd_idx;
        logic [IDX_W-1:0]      back_idx;
    } cell_cmd_t;

    // Zero-extend or truncate an entry to the port field width.
    function automatic logic [FIELD_W-1:0] to_field(input logic [ITEM_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_W-1:0];
    endfunction

    // Keep the low ITEM_WIDTH bits of an incoming field.
    function automatic logic [ITEM_WIDTH-1:0] from_field(input logic [FIELD_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[ITEM_WIDTH-1:0];
    endfunction

endpackage

### src/indexed_sequence_store.sv
`timescale 1ns / 1ps

// Bounded ordered sequence of item words with list operations.
// Input channel (in_valid / in_ready) carries one operation per beat: kind,
// position and item_value. Result channel (res_valid / res_ready) carries one
// result beat per operation: the item removed or read with its out_valid flag,
// a status code, and the length, first and last entries after the operation.
// The entries live in a row of identical cells; every cell compares its own
// index against the operation's position and in the same cycle either keeps
// its word, takes the new word, or takes the word of a neighbor, so an insert
// or remove shifts the whole tail at once.
// Results are registered: a beat accepted at one edge is shown on the
// result port right after that edge. Throughput is one operation per cycle
// while results are taken, set by the cell update and the one-deep result register.
// in_ready is high while the result register is empty or is being drained
// in the same cycle, so a stalled receiver holds the result steady and
// back-pressures the input after exactly one pending result.
// Reset empties the sequence (the count goes to zero) and drops any pending
// result; the cell contents are not cleared and are never read before being
// written.
module indexed_sequence_store
    import isq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [POS_W-1:0]    position,
    input  logic [FIELD_W-1:0]  item_value,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [FIELD_W-1:0]  out_item,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  count_now,
    output logic [FIELD_W-1:0]  front_item,
    output logic [FIELD_W-1:0]  back_item
);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  res_valid_reg;
    logic [FIELD_W-1:0]    out_item_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [COUNT_W-1:0]    count_now_reg;
    logic [FIELD_W-1:0]    front_item_reg;
    logic [FIELD_W-1:0]    back_item_reg;

    logic                  accept;
    shift_t                shift;
    logic [IDX_W-1:0]      at;
    logic                  hit;
    status_t               st;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      cnt_cmp;
    logic                  full;
    logic                  empty;
    cell_cmd_t             cmd;

    logic [ITEM_WIDTH-1:0] entry_arr [CAPACITY];
    logic [ITEM_WIDTH-1:0] next_arr  [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_arr    [CAPACITY];
    logic [ITEM_WIDTH-1:0] back_arr  [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_word;
    logic [ITEM_WIDTH-1:0] back_word;
    logic [63:0]           count_wide;

    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    assign pos_cmp = CMP_W'(position);
    assign cnt_cmp = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Decode the operation against the current length.
    always_comb
    begin
        shift = SH_NONE;
        at    = '0;
        hit   = 1'b0;
        st    = ST_OK;
        unique case (kind_t'(kind))
            K_PUSH_FRONT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    shift = SH_OPEN;
                end
            end
            K_PUSH_BACK:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    shift = SH_OPEN;
                    at    = IDX_W'(count_reg);
                end
            end
            K_INSERT_AT:
            begin
                if (pos_cmp > cnt_cmp)
                begin
                    st = ST_RANGE;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    shift = SH_OPEN;
                    at    = IDX_W'(position);
                end
            end
            K_POP_FRONT:
            begin
                if (!empty)
                begin
                    shift = SH_CLOSE;
                    hit   = 1'b1;
                end
            end
            K_POP_BACK:
            begin
                if (!empty)
                begin
                    shift = SH_CLOSE;
                    at    = IDX_W'(count_reg - CNT_W'(1));
                    hit   = 1'b1;
                end
            end
            K_REMOVE_AT:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    shift = SH_CLOSE;
                    at    = IDX_W'(position);
                    hit   = 1'b1;
                end
            end
            K_READ_AT:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    at  = IDX_W'(position);
                    hit = 1'b1;
                end
            end
            default:
            begin
                shift = SH_NONE;
            end
        endcase
    end

    // Length after the operation; the cells only move on an accepted beat.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            unique case (shift)
                SH_OPEN:  count_next = count_reg + CNT_W'(1);
                SH_CLOSE: count_next = count_reg - CNT_W'(1);
                default:  count_next = count_reg;
            endcase
        end
    end

    assign cmd.op       = accept ? shift : SH_NONE;
    assign cmd.at       = at;
    assign cmd.count    = count_reg;
    assign cmd.value    = from_field(item_value);
    assign cmd.rd_idx   = at;
    assign cmd.back_idx = IDX_W'(count_next - CNT_W'(1));

    // The row of cells; the first and last cells see zero past the ends.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_w;
        logic [ITEM_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_arr[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_arr[g+1];
        end

        isq_cell u_cell (
            .clk         (clk),
            .index       (IDX_W'(g)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_arr[g]),
            .entry_next  (next_arr[g]),
            .rd_term     (rd_arr[g]),
            .back_term   (back_arr[g])
        );
    end

    // Only one cell matches each select, so the buses are plain ORs.
    always_comb
    begin
        rd_word   = '0;
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word   = rd_word | rd_arr[i];
            back_word = back_word | back_arr[i];
        end
    end

    assign count_wide = 64'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; a pending result holds until the receiver takes it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg   <= hit ? to_field(rd_word) : '0;
            out_valid_reg  <= hit;
            status_reg     <= st;
            count_now_reg  <= count_wide[COUNT_W-1:0];
            front_item_reg <= (count_next != '0) ? to_field(next_arr[0]) : '0;
            back_item_reg  <= (count_next != '0) ? to_field(back_word) : '0;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_item   = out_item_reg;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count_now  = count_now_reg;
    assign front_item = front_item_reg;
    assign back_item  = back_item_reg;

endmodule

### src/isq_cell.sv
`timescale 1ns / 1ps

module isq_cell
    import isq_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      index,
    input  cell_cmd_t             cmd,
    input  logic [ITEM_WIDTH-1:0] left_entry,
    input  logic [ITEM_WIDTH-1:0] right_entry,
    output logic [ITEM_WIDTH-1:0] entry,
    output logic [ITEM_WIDTH-1:0] entry_next,
    output logic [ITEM_WIDTH-1:0] rd_term,
    output logic [ITEM_WIDTH-1:0] back_term
);

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [CNT_W-1:0]      index_cnt;

    assign index_cnt = CNT_W'(index);

    // Each cell decides from its own position whether it keeps its word,
    // takes the new word, or takes a neighbor's word.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            SH_OPEN:
            begin
                if (index == cmd.at)
                begin
                    entry_next = cmd.value;
                end
                else if (index > cmd.at && index_cnt <= cmd.count)
                begin
                    entry_next = left_entry;
                end
            end
            SH_CLOSE:
            begin
                if (index >= cmd.at && (index_cnt + CNT_W'(1)) < cmd.count)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign rd_term   = (index == cmd.rd_idx)   ? entry_reg  : '0;
    assign back_term = (index == cmd.back_idx) ? entry_next : '0;

endmodule
